/* design/gdd_pkg.sv */
// gregorian date difference: shared types, widths, constants and calendar tables
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int DAY_W    = 5;
    localparam int MON_W    = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 22;
    localparam int SERIAL_W = YEAR_W + 9;

    localparam int MAX_YEAR      = 9999;
    localparam int DAYS_PER_YEAR = 365;

    // x / 25 == (x * RECIP_25) >> RECIP_SHIFT, exact for x below 2**12
    localparam int RECIP_25    = 5243;
    localparam int RECIP_SHIFT = 17;
    localparam int DIV25_IN_W  = YEAR_W - 2;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = DIV25_IN_W + RECIP_W;
    localparam int Q100_W      = PROD_W - RECIP_SHIFT;
    localparam int MSTART_W    = 9;

    localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]  first_day;
        logic [MON_W-1:0]  first_month;
        logic [YEAR_W-1:0] first_year;
        logic [DAY_W-1:0]  second_day;
        logic [MON_W-1:0]  second_month;
        logic [YEAR_W-1:0] second_year;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               status;
    } t_out_item;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
    } t_date;

    // serial day number of one date, with its validity
    typedef struct packed {
        logic                ok;
        logic [SERIAL_W-1:0] serial;
    } t_date_num;

    function automatic logic [DAY_W-1:0] month_length(input logic [MON_W-1:0] m,
                                                      input logic leap);
        case (m) inside
            MONTH_FEB:                 return leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
            default:                   return 5'd31;
        endcase
    endfunction

    // days in the whole months before month m of a common year
    function automatic logic [MSTART_W-1:0] month_start(input logic [MON_W-1:0] m);
        case (m)
            4'd2:    return 9'd31;
            4'd3:    return 9'd59;
            4'd4:    return 9'd90;
            4'd5:    return 9'd120;
            4'd6:    return 9'd151;
            4'd7:    return 9'd181;
            4'd8:    return 9'd212;
            4'd9:    return 9'd243;
            4'd10:   return 9'd273;
            4'd11:   return 9'd304;
            4'd12:   return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

endpackage

/* design/gdd_date_num.sv */
// gregorian date difference: three-stage pipeline from one date to its serial day number
// depends on gdd_pkg
`timescale 1ns / 1ps

module gdd_date_num (
    input  logic              i_clk,
    input  gdd_pkg::t_date     i_date,
    output gdd_pkg::t_date_num o_num
);
    import gdd_pkg::*;

    // stage 1: constant divisions by reciprocal multiply, month and year range checks
    logic [YEAR_W-1:0]     w_p;
    logic [PROD_W-1:0]     w_p100_prod;
    logic [PROD_W-1:0]     w_p400_prod;
    logic [PROD_W-1:0]     w_y100_prod;
    logic [PROD_W-1:0]     w_y400_prod;

    t_date                 r1_date;
    logic [YEAR_W-1:0]     r1_p;
    logic [Q100_W-1:0]     r1_p100;
    logic [Q100_W-1:0]     r1_p400;
    logic [Q100_W-1:0]     r1_y100;
    logic [Q100_W-1:0]     r1_y400;
    logic                  r1_mok;
    logic                  r1_yok;

    assign w_p         = i_date.year - YEAR_W'(1);
    assign w_p100_prod = PROD_W'(w_p >> 2) * PROD_W'(RECIP_25);
    assign w_p400_prod = PROD_W'(w_p >> 4) * PROD_W'(RECIP_25);
    assign w_y100_prod = PROD_W'(i_date.year >> 2) * PROD_W'(RECIP_25);
    assign w_y400_prod = PROD_W'(i_date.year >> 4) * PROD_W'(RECIP_25);

    always_ff @(posedge i_clk) begin
        r1_date <= i_date;
        r1_p    <= w_p;
        r1_p100 <= w_p100_prod[PROD_W-1:RECIP_SHIFT];
        r1_p400 <= w_p400_prod[PROD_W-1:RECIP_SHIFT];
        r1_y100 <= w_y100_prod[PROD_W-1:RECIP_SHIFT];
        r1_y400 <= w_y400_prod[PROD_W-1:RECIP_SHIFT];
        r1_mok  <= (i_date.month >= MONTH_JAN) && (i_date.month <= MONTH_DEC);
        r1_yok  <= (i_date.year != '0) &&
                   ((YEAR_W + 3)'(i_date.year) <= (YEAR_W + 3)'(MAX_YEAR));
    end

    // stage 2: leap rule, day check, whole-year days and day-of-year offset
    logic                  w_div100;
    logic                  w_div400;
    logic                  w_leap;
    logic [DAY_W-1:0]      w_mlen;
    logic                  w_dok;

    logic [SERIAL_W-1:0]   r2_years;
    logic [MSTART_W+DAY_W-1:0] r2_offset;
    logic                  r2_ok;

    // y divisible by 100 when y/4 is a multiple of 25, by 400 when y/16 is
    assign w_div100 = (r1_date.year[1:0] == 2'b00) &&
                      ((r1_date.year >> 2) == (YEAR_W'(r1_y100) * YEAR_W'(25)));
    assign w_div400 = (r1_date.year[3:0] == 4'b0000) &&
                      ((r1_date.year >> 4) == (YEAR_W'(r1_y400) * YEAR_W'(25)));
    assign w_leap   = ((r1_date.year[1:0] == 2'b00) && !w_div100) || w_div400;
    assign w_mlen   = month_length(r1_date.month, w_leap);
    assign w_dok    = (r1_date.day != '0) && (r1_date.day <= w_mlen);

    always_ff @(posedge i_clk) begin
        r2_years  <= SERIAL_W'(r1_p) * SERIAL_W'(DAYS_PER_YEAR)
                   + SERIAL_W'(r1_p >> 2) - SERIAL_W'(r1_p100);
        r2_offset <= (MSTART_W + DAY_W)'(month_start(r1_date.month))
                   + (MSTART_W + DAY_W)'(w_leap && (r1_date.month > MONTH_FEB))
                   + (MSTART_W + DAY_W)'(r1_date.day)
                   + (MSTART_W + DAY_W)'(r1_p400);
        r2_ok     <= r1_mok && r1_yok && w_dok;
    end

    // stage 3: serial day number, 1 january of year 1 is day 1
    t_date_num r3_num;

    always_ff @(posedge i_clk) begin
        r3_num.ok     <= r2_ok;
        r3_num.serial <= r2_years + SERIAL_W'(r2_offset);
    end

    assign o_num = r3_num;

endmodule

/* design/gdd_diff.sv */
// gregorian date difference: absolute difference, saturation and output register
// depends on gdd_pkg
`timescale 1ns / 1ps

module gdd_diff (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  gdd_pkg::t_date_num  i_a,
    input  gdd_pkg::t_date_num  i_b,
    output logic               o_done,
    output gdd_pkg::t_out_item  o_result
);
    import gdd_pkg::*;

    logic [SERIAL_W:0]   w_ab;
    logic [SERIAL_W:0]   w_ba;
    logic [SERIAL_W-1:0] w_abs;
    logic [COUNT_W-1:0]  w_sat;
    logic                w_bad;

    logic                r_done;
    t_out_item           r_result;

    assign w_ab  = {1'b0, i_a.serial} - {1'b0, i_b.serial};
    assign w_ba  = {1'b0, i_b.serial} - {1'b0, i_a.serial};
    // borrow out means b is the later date
    assign w_abs = w_ab[SERIAL_W] ? w_ba[SERIAL_W-1:0] : w_ab[SERIAL_W-1:0];
    assign w_sat = (w_abs[SERIAL_W-1:COUNT_W] != '0) ? '1 : w_abs[COUNT_W-1:0];
    assign w_bad = !(i_a.ok && i_b.ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_vld;
        end
        r_result.status    <= w_bad;
        r_result.day_count <= w_bad ? '0 : w_sat;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* design/gregorian_date_difference.sv */
// days between two gregorian dates, one item accepted per cycle, fully pipelined
// throughput: one item per cycle; o_busy stays low since the receiver cannot stall
// stages: reciprocal divides, leap and day check, serial number, difference and saturation
// reset: synchronous active low, clears the valid bits only; no items in flight after it
// depends on gdd_pkg, gdd_date_num, gdd_diff
`timescale 1ns / 1ps

module gregorian_date_difference (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  gdd_pkg::t_in_item  i_item,
    output logic              o_done,
    output gdd_pkg::t_out_item o_result
);
    import gdd_pkg::*;

    t_date     w_first;
    t_date     w_second;
    t_date_num w_num_a;
    t_date_num w_num_b;
    logic      w_accept;
    logic [2:0] r_vld;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    assign w_first  = '{day: i_item.first_day, month: i_item.first_month,
                        year: i_item.first_year};
    assign w_second = '{day: i_item.second_day, month: i_item.second_month,
                        year: i_item.second_year};

    // valid bits beside the three date stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], w_accept};
        end
    end

    gdd_date_num u_first (
        .i_clk  (i_clk),
        .i_date (w_first),
        .o_num  (w_num_a)
    );

    gdd_date_num u_second (
        .i_clk  (i_clk),
        .i_date (w_second),
        .o_num  (w_num_b)
    );

    gdd_diff u_diff (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_vld[2]),
        .i_a      (w_num_a),
        .i_b      (w_num_b),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_done)
        else $error("accepted item did not produce a result after four cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_vld[2]))
        else $error("result strobe without a valid item");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status) |-> (o_result.day_count == '0))
        else $error("invalid item gave a nonzero day count");

    a_bad_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((i_item.first_month == '0) || (i_item.second_month == '0)))
        |-> ##4 (o_done && o_result.status))
        else $error("month zero not flagged as invalid");

    a_same_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.first_day == i_item.second_day)
                  && (i_item.first_month == i_item.second_month)
                  && (i_item.first_year == i_item.second_year))
        |-> ##4 (o_result.day_count == '0))
        else $error("identical dates gave a nonzero day count");

endmodule
